// ===== rtl/core/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths, micro-op encodings and the control store for the
// modular exponentiation sequencer
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MOD_W       = 31;
    localparam int BASE_W      = 32;
    localparam int EXP_W_MAX   = 63;
    localparam int EXP_WIDTH_DEF = 63;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 32;
    localparam int PC_W        = 4;

    localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

    // multiplier operand / destination choice
    typedef enum logic [1:0] {
        MS_RED,   // b = 1 * b mod m  (base reduction)
        MS_RMUL,  // r = r * b mod m
        MS_SQR    // b = b * b mod m, exponent shifts
    } t_mul_sel;

    typedef enum logic [1:0] {
        RI_KEEP,
        RI_ONE,
        RI_ZERO,
        RI_ONEMOD
    } t_r_init;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_EZERO,
        C_MZERO,
        C_ELSB0,
        C_MORE
    } t_cond;

    typedef struct packed {
        logic            wait_in;
        logic            emit;
        logic            mul_en;
        t_mul_sel        mul_sel;
        t_r_init         r_init;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // request from the sequencer to the modular multiplier
    typedef struct packed {
        logic              start;
        logic [MOD_W-1:0]  x;
        logic [BASE_W-1:0] y;
    } t_mul_req;

    // program addresses
    localparam logic [PC_W-1:0] PC_WAIT   = 4'd0;
    localparam logic [PC_W-1:0] PC_CHK_E  = 4'd1;
    localparam logic [PC_W-1:0] PC_CHK_M  = 4'd2;
    localparam logic [PC_W-1:0] PC_INIT_R = 4'd3;
    localparam logic [PC_W-1:0] PC_RED    = 4'd4;
    localparam logic [PC_W-1:0] PC_LOOP   = 4'd5;
    localparam logic [PC_W-1:0] PC_RMUL   = 4'd6;
    localparam logic [PC_W-1:0] PC_SQR    = 4'd7;
    localparam logic [PC_W-1:0] PC_EMIT   = 4'd8;

    localparam t_uword UW_NOP = '{
        wait_in: 1'b0, emit: 1'b0, mul_en: 1'b0, mul_sel: MS_RED,
        r_init: RI_KEEP, cond: C_NEVER, target: PC_WAIT
    };

    // control store
    function automatic t_uword f_rom(input logic [PC_W-1:0] a);
        t_uword w;
        w = UW_NOP;
        case (a)
            PC_WAIT: begin
                w.wait_in = 1'b1;
            end
            PC_CHK_E: begin
                w.r_init = RI_ONE;
                w.cond   = C_EZERO;
                w.target = PC_EMIT;
            end
            PC_CHK_M: begin
                w.r_init = RI_ZERO;
                w.cond   = C_MZERO;
                w.target = PC_EMIT;
            end
            PC_INIT_R: begin
                w.r_init = RI_ONEMOD;
            end
            PC_RED: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MS_RED;
            end
            PC_LOOP: begin
                w.cond   = C_ELSB0;
                w.target = PC_SQR;
            end
            PC_RMUL: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MS_RMUL;
            end
            PC_SQR: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MS_SQR;
                w.cond    = C_MORE;
                w.target  = PC_LOOP;
            end
            PC_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = PC_WAIT;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = PC_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// bit-serial modular multiplier, x * y mod m, one bit of y per cycle
// ----------------------------------------------------------------------------
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mul_req         i_req,
    input  logic [MOD_W-1:0] i_m,
    output logic             o_done,
    output logic [MOD_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(BASE_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [MOD_W-1:0]  r_acc;
    logic [MOD_W-1:0]  r_x;
    logic [BASE_W-1:0] r_y;

    logic [MOD_W-1:0]  n_acc;
    logic [MOD_W+1:0]  s_acc2;
    logic [MOD_W+2:0]  s_d1;
    logic [MOD_W+2:0]  s_d2;
    logic              s_last;

    // 2*acc + bit*x stays below 3m, so at most two subtractions of m
    always_comb begin
        s_acc2 = {1'b0, r_acc, 1'b0}
               + (r_y[BASE_W-1] ? {2'b00, r_x} : {(MOD_W+2){1'b0}});
        s_d1   = {1'b0, s_acc2} - {3'b000, i_m};
        s_d2   = {1'b0, s_acc2} - {2'b00, i_m, 1'b0};
        if (!s_d2[MOD_W+2]) begin
            n_acc = s_d2[MOD_W-1:0];
        end else if (!s_d1[MOD_W+2]) begin
            n_acc = s_d1[MOD_W-1:0];
        end else begin
            n_acc = s_acc2[MOD_W-1:0];
        end
        s_last = (r_cnt == CNT_W'(BASE_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (s_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_x   <= i_req.x;
            r_y   <= i_req.y;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[BASE_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    a_no_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiplier started while busy");

    a_done_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("done without a finished run");

    a_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_acc < i_m))
        else $error("product not reduced below modulus");

endmodule

// ===== rtl/core/modular_exponentiation_top.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// base ** exponent mod modulus, right-to-left square and multiply
// ----------------------------------------------------------------------------
// sequence: a zero exponent or a zero modulus skips straight to the result;
//   otherwise the base is reduced, then one square runs per exponent bit up to
//   and including the highest set bit, with one extra multiply for each set
//   bit; every modular multiply runs in the bit-serial unit
// throughput: one item at a time; the next item is taken once the result
//   has moved into the output register, even while that result still waits
// reset: synchronous active-low; modulus returns to 1000000007, the
//   sequencer goes to its wait step and the output register empties
// ----------------------------------------------------------------------------
module modular_exponentiation_top
    import mexp_pkg::*;
#(
    parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // base[31:0], exponent[94:32]
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // power[30:0]
    // modulus register write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [MOD_W-1:0]       i_cfg_data
);

    // program state
    logic [PC_W-1:0]      r_pc;
    logic [PC_W-1:0]      n_pc;
    logic                 r_issued;     // multiply of this step already started
    logic                 n_issued;
    logic                 r_out_valid;
    logic                 n_out_valid;

    // datapath
    logic [MOD_W-1:0]     r_m;          // modulus
    logic [BASE_W-1:0]    r_b;          // base, later the running square
    logic [BASE_W-1:0]    n_b;
    logic [EXP_WIDTH-1:0] r_e;          // exponent, shifted right per square
    logic [EXP_WIDTH-1:0] n_e;
    logic [MOD_W-1:0]     r_r;          // running result
    logic [MOD_W-1:0]     n_r;
    logic [MOD_W-1:0]     r_power;
    logic [MOD_W-1:0]     n_power;

    t_uword               s_w;
    logic                 s_take;
    logic                 s_in_acc;
    t_mul_req             s_mul_req;
    logic                 s_mul_done;
    logic [MOD_W-1:0]     s_mul_prod;

    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_mul_req),
        .i_m     (r_m),
        .o_done  (s_mul_done),
        .o_prod  (s_mul_prod)
    );

    always_comb begin
        s_w      = f_rom(r_pc);
        s_in_acc = s_axis_tvalid && s_w.wait_in;

        // branch condition of the current micro-step
        case (s_w.cond)
            C_NEVER:  s_take = 1'b0;
            C_ALWAYS: s_take = 1'b1;
            C_EZERO:  s_take = (r_e == '0);
            C_MZERO:  s_take = (r_m == '0);
            C_ELSB0:  s_take = !r_e[0];
            C_MORE:   s_take = ((r_e >> 1) != '0);
            default:  s_take = 1'b0;
        endcase

        // multiplier operands: y is always the square, x picks the other side
        s_mul_req.start = 1'b0;
        s_mul_req.y     = r_b;
        case (s_w.mul_sel)
            MS_RED:  s_mul_req.x = MOD_W'(1);
            MS_RMUL: s_mul_req.x = r_r;
            MS_SQR:  s_mul_req.x = r_b[MOD_W-1:0];
            default: s_mul_req.x = r_b[MOD_W-1:0];
        endcase

        n_pc        = r_pc;
        n_issued    = r_issued;
        n_b         = r_b;
        n_e         = r_e;
        n_r         = r_r;
        n_power     = r_power;
        n_out_valid = r_out_valid;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (s_w.wait_in) begin
            // load a new item
            if (s_in_acc) begin
                n_b  = s_axis_tdata[BASE_W-1:0];
                n_e  = s_axis_tdata[BASE_W +: EXP_WIDTH];
                n_pc = r_pc + 1'b1;
            end
        end else if (s_w.emit) begin
            // hand the result to the output register once it has room
            if (!r_out_valid || m_axis_tready) begin
                n_out_valid = 1'b1;
                n_power     = r_r;
                n_pc        = s_w.target;
            end
        end else if (s_w.mul_en) begin
            if (!r_issued) begin
                s_mul_req.start = 1'b1;
                n_issued        = 1'b1;
            end else if (s_mul_done) begin
                n_issued = 1'b0;
                case (s_w.mul_sel)
                    MS_RMUL: n_r = s_mul_prod;
                    MS_SQR: begin
                        n_b = {1'b0, s_mul_prod};
                        n_e = r_e >> 1;
                    end
                    default: n_b = {1'b0, s_mul_prod};
                endcase
                n_pc = s_take ? s_w.target : r_pc + 1'b1;
            end
        end else begin
            // result seeding; one mod m is zero for a modulus of one
            case (s_w.r_init)
                RI_ONE:    n_r = MOD_W'(1);
                RI_ZERO:   n_r = '0;
                RI_ONEMOD: n_r = (r_m == MOD_W'(1)) ? '0 : MOD_W'(1);
                default:   n_r = r_r;
            endcase
            n_pc = s_take ? s_w.target : r_pc + 1'b1;
        end
    end

    // control state and modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_WAIT;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_m         <= MOD_RESET;
        end else begin
            r_pc        <= n_pc;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_m <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_b     <= n_b;
        r_e     <= n_e;
        r_r     <= n_r;
        r_power <= n_power;
    end

    assign s_axis_tready = s_w.wait_in;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - MOD_W){1'b0}}, r_power};
    assign o_cfg_ready   = 1'b1;

endmodule
